### sv/gha_pkg.sv
// Package for the generational handle allocator: request and response
// transfer types and the request and status codes. No dependencies.
`default_nettype none

package gha_pkg;

    localparam int FIELD_W = 16;
    localparam int OWNER_W = 32;

    // Request codes.
    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_HELD = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;
    localparam logic [1:0] STATUS_MISS = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [FIELD_W-1:0] handle;
        logic [OWNER_W-1:0] owner_tag;
    } gha_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] result_handle;
        logic [OWNER_W-1:0] result_owner;
        logic [1:0]         status;
    } gha_rsp_t;

endpackage

`default_nettype wire

### sv/gha_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// A read and a write to the same address in one cycle return the old data.
`default_nettype none

module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/generational_handle_allocator_unit.sv
// Top level of the generational handle allocator: slot table, free stack and
// the request pipeline. Depends on gha_pkg and gha_ram.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------
//  req     | in        | req_valid, req_stall | gha_req_t
//  rsp     | out       | rsp_valid, rsp_stall | gha_rsp_t
//
// One request per cycle while the response side does not stall. An accepted
// request has the slot table and free stack read into the RAM registers;
// the execute stage resolves it, writes back and registers its response.
// A request directly behind a table or stack write gets the written data
// through a bypass register, so back-to-back requests never wait.
// Reset needs no clearing pass: slots at or above the fresh-slot counter are
// treated as never allocated. A stalled response holds the pipeline stage,
// which then stalls the request side.
`default_nettype none

module generational_handle_allocator_unit
    import gha_pkg::*;
#(
    parameter int SLOT_BITS = 8,
    parameter int GEN_BITS  = 8
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire gha_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output gha_rsp_t      rsp
);

    localparam int HW    = SLOT_BITS + GEN_BITS;
    localparam int CW    = (HW > FIELD_W) ? HW : FIELD_W;
    localparam int SW    = 1 + HW + OWNER_W;
    localparam int DEPTH = 1 << SLOT_BITS;

    // Slot table word: live bit, stored handle, owner tag.
    logic                 s1_valid_reg;
    gha_req_t             s1_req_reg;
    logic                 byp_slot_hit_reg;
    logic [SW-1:0]        byp_slot_data_reg;
    logic                 byp_stk_hit_reg;
    logic [HW-1:0]        byp_stk_data_reg;
    logic                 rsp_valid_reg;
    gha_rsp_t             rsp_reg;
    logic [SLOT_BITS:0]   free_count_reg;
    logic [SLOT_BITS:0]   next_fresh_reg;
    logic [SLOT_BITS:0]   free_count_next;
    logic [SLOT_BITS:0]   next_fresh_next;

    logic                 accept;
    logic                 s1_fire;

    logic [SW-1:0]        slot_rd;
    logic [HW-1:0]        stk_rd;

    logic                 slot_we;
    logic [SLOT_BITS-1:0] slot_waddr;
    logic [SW-1:0]        slot_wdata;
    logic                 stk_we;
    logic [SLOT_BITS-1:0] stk_waddr;
    logic [HW-1:0]        stk_wdata;
    gha_rsp_t             rsp_d;

    logic [CW-1:0]        req_h_ext;
    logic [SLOT_BITS-1:0] slot_raddr;
    logic [SLOT_BITS:0]   stk_top_idx;
    logic [SLOT_BITS-1:0] stk_raddr;

    // Execute stage signals.
    logic [CW-1:0]        h_ext;
    logic [SLOT_BITS-1:0] s;
    logic [SW-1:0]        slot_word;
    logic [HW-1:0]        stk_word;
    logic [HW-1:0]        stored_h;
    logic                 hit;
    logic [GEN_BITS-1:0]  new_gen;
    logic [HW-1:0]        nh;
    logic [SLOT_BITS-1:0] nslot;

    assign s1_fire   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !s1_fire;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Resolve the request held in the execute stage.
    always_comb
    begin
        h_ext     = CW'(s1_req_reg.handle);
        s         = h_ext[SLOT_BITS-1:0];
        slot_word = byp_slot_hit_reg ? byp_slot_data_reg : slot_rd;
        stk_word  = byp_stk_hit_reg ? byp_stk_data_reg : stk_rd;
        stored_h  = slot_word[SW-2:OWNER_W];
        hit       = (s != '0) && ({1'b0, s} < next_fresh_reg) && slot_word[SW-1]
                    && (CW'(stored_h) == h_ext);
        new_gen   = stk_word[HW-1:SLOT_BITS] + 1'b1;
        nh        = '0;
        nslot     = '0;

        slot_we         = 1'b0;
        slot_waddr      = s;
        slot_wdata      = {1'b0, stored_h, slot_word[OWNER_W-1:0]};
        stk_we          = 1'b0;
        stk_waddr       = free_count_reg[SLOT_BITS-1:0];
        stk_wdata       = h_ext[HW-1:0];
        free_count_next = free_count_reg;
        next_fresh_next = next_fresh_reg;
        rsp_d           = '{result_handle: '0, result_owner: '0, status: STATUS_MISS};

        case (s1_req_reg.req_type)
            REQ_ALLOC:
            begin
                if (s1_req_reg.handle != '0)
                begin
                    rsp_d.result_handle = s1_req_reg.handle;
                    rsp_d.status        = STATUS_HELD;
                end
                else if (free_count_reg != '0)
                begin
                    nslot           = stk_word[SLOT_BITS-1:0];
                    nh              = {new_gen, nslot};
                    free_count_next = free_count_reg - 1'b1;
                    slot_we         = 1'b1;
                end
                else if (!next_fresh_reg[SLOT_BITS])
                begin
                    nslot           = next_fresh_reg[SLOT_BITS-1:0];
                    nh              = {{GEN_BITS{1'b0}}, nslot};
                    next_fresh_next = next_fresh_reg + 1'b1;
                    slot_we         = 1'b1;
                end
                else
                begin
                    rsp_d.status = STATUS_FULL;
                end
                if (slot_we)
                begin
                    slot_waddr          = nslot;
                    slot_wdata          = {1'b1, nh, s1_req_reg.owner_tag};
                    rsp_d.result_handle = FIELD_W'(nh);
                    rsp_d.status        = STATUS_OK;
                end
            end
            REQ_FREE:
            begin
                if (hit)
                begin
                    slot_we = 1'b1;
                    // When the stack is already full the push is dropped.
                    if (!free_count_reg[SLOT_BITS])
                    begin
                        stk_we          = 1'b1;
                        free_count_next = free_count_reg + 1'b1;
                    end
                    rsp_d.result_handle = s1_req_reg.handle;
                    rsp_d.status        = STATUS_OK;
                end
            end
            REQ_LOOKUP:
            begin
                if (hit)
                begin
                    rsp_d.result_handle = s1_req_reg.handle;
                    rsp_d.result_owner  = slot_word[OWNER_W-1:0];
                    rsp_d.status        = STATUS_OK;
                end
            end
            default:
            begin
                rsp_d.status = STATUS_MISS;
            end
        endcase

        if (!s1_fire)
        begin
            slot_we         = 1'b0;
            stk_we          = 1'b0;
            free_count_next = free_count_reg;
            next_fresh_next = next_fresh_reg;
        end
    end

    // Read addresses for the incoming request, taken against the state that
    // the execute stage leaves behind.
    always_comb
    begin
        req_h_ext   = CW'(req.handle);
        slot_raddr  = req_h_ext[SLOT_BITS-1:0];
        stk_top_idx = free_count_next - 1'b1;
        stk_raddr   = stk_top_idx[SLOT_BITS-1:0];
    end

    gha_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (accept),
        .raddr (slot_raddr),
        .rdata (slot_rd)
    );

    gha_ram #(
        .WIDTH (HW),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (accept),
        .raddr (stk_raddr),
        .rdata (stk_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            byp_slot_hit_reg <= 1'b0;
            byp_stk_hit_reg  <= 1'b0;
            free_count_reg   <= '0;
            next_fresh_reg   <= (SLOT_BITS+1)'(1);
        end
        else
        begin
            free_count_reg <= free_count_next;
            next_fresh_reg <= next_fresh_next;
            if (accept)
            begin
                s1_valid_reg     <= 1'b1;
                byp_slot_hit_reg <= slot_we && (slot_waddr == slot_raddr);
                byp_stk_hit_reg  <= stk_we && (stk_waddr == stk_raddr);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg        <= req;
            byp_slot_data_reg <= slot_wdata;
            byp_stk_data_reg  <= stk_wdata;
        end
        if (s1_fire)
        begin
            rsp_reg <= rsp_d;
        end
    end

endmodule

`default_nettype wire

### test/testbench.sv
// Testbench for generational_handle_allocator_unit: directed and random requests
// checked field by field against a built-in model of the slot table and free stack.
// Depends on gha_pkg and the allocator RTL.
`default_nettype none

module testbench;
    import gha_pkg::*;

    localparam int SLOT_BITS    = 8;
    localparam int GEN_BITS     = 8;
    localparam int NUM_SLOTS    = 1 << SLOT_BITS;
    localparam int PLAN         = 0;
    localparam int CHECK        = 1;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 8;
    localparam int CHURN_PAIRS  = 256;
    localparam int LIMIT        = 200000;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    gha_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    gha_rsp_t rsp;

    // Two copies of the allocator state: one advanced while the stimulus is
    // planned, one advanced as the block accepts each transfer.
    logic [FIELD_W-1:0] tbl_handle    [2][NUM_SLOTS];
    logic [OWNER_W-1:0] tbl_owner     [2][NUM_SLOTS];
    bit                 tbl_live      [2][NUM_SLOTS];
    logic [FIELD_W-1:0] recycle_stack [2][NUM_SLOTS];
    int                 recycle_count [2];
    int                 fresh_slot    [2];

    gha_req_t pending[$];
    gha_rsp_t expected[$];
    gha_rsp_t want_rsp;
    int       n_items = 0;
    int       n_accepted = 0;
    int       n_errors = 0;
    int       cycle_count = 0;

    generational_handle_allocator_unit #(
        .SLOT_BITS(SLOT_BITS),
        .GEN_BITS (GEN_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic void clear_model(input int v);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tbl_handle[v][i] = '0;
            tbl_owner[v][i] = '0;
            tbl_live[v][i] = 1'b0;
            recycle_stack[v][i] = '0;
        end
        recycle_count[v] = 0;
        fresh_slot[v] = 1;
    endfunction

    // Applies one request to model copy v and returns the response it gives.
    function automatic gha_rsp_t serve(input int v, input gha_req_t r);
        gha_rsp_t           o;
        logic [FIELD_W-1:0] h;
        logic [FIELD_W-1:0] prev;
        logic [FIELD_W-1:0] nh;
        logic [GEN_BITS-1:0] gen;
        int                 s;
        bit                 hit;
        h = r.handle;
        s = int'(h[SLOT_BITS-1:0]);
        hit = (s != 0) && tbl_live[v][s] && (tbl_handle[v][s] == h);
        nh = '0;
        o = '0;
        o.status = STATUS_MISS;
        case (r.req_type)
            REQ_ALLOC:
            begin
                if (h != '0)
                begin
                    o.result_handle = h;
                    o.status = STATUS_HELD;
                end
                else
                begin
                    s = 0;
                    if (recycle_count[v] > 0)
                    begin
                        recycle_count[v] = recycle_count[v] - 1;
                        prev = recycle_stack[v][recycle_count[v]];
                        gen = prev[SLOT_BITS +: GEN_BITS] + 1'b1;
                        s = int'(prev[SLOT_BITS-1:0]);
                        nh = {gen, prev[SLOT_BITS-1:0]};
                    end
                    else if (fresh_slot[v] < NUM_SLOTS)
                    begin
                        s = fresh_slot[v];
                        nh = FIELD_W'(s);
                        fresh_slot[v] = fresh_slot[v] + 1;
                    end
                    if (s == 0)
                    begin
                        o.status = STATUS_FULL;
                    end
                    else
                    begin
                        tbl_handle[v][s] = nh;
                        tbl_owner[v][s] = r.owner_tag;
                        tbl_live[v][s] = 1'b1;
                        o.result_handle = nh;
                        o.status = STATUS_OK;
                    end
                end
            end
            REQ_FREE:
            begin
                if (hit)
                begin
                    tbl_live[v][s] = 1'b0;
                    if (recycle_count[v] < NUM_SLOTS)
                    begin
                        recycle_stack[v][recycle_count[v]] = h;
                        recycle_count[v] = recycle_count[v] + 1;
                    end
                    o.result_handle = h;
                    o.status = STATUS_OK;
                end
            end
            REQ_LOOKUP:
            begin
                if (hit)
                begin
                    o.result_handle = h;
                    o.result_owner = tbl_owner[v][s];
                    o.status = STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    function automatic void add_item(input logic [1:0] t, input logic [FIELD_W-1:0] h,
                                     input logic [OWNER_W-1:0] tag);
        gha_req_t it;
        it.req_type = t;
        it.handle = h;
        it.owner_tag = tag;
        void'(serve(PLAN, it));
        pending = {pending, it};
    endfunction

    function automatic logic [FIELD_W-1:0] pick_live();
        int start;
        int s;
        start = $urandom_range(NUM_SLOTS - 2);
        for (int i = 0; i < NUM_SLOTS - 1; i++)
        begin
            s = 1 + (start + i) % (NUM_SLOTS - 1);
            if (tbl_live[PLAN][s])
                return tbl_handle[PLAN][s];
        end
        return '0;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_stale();
        int                  s;
        logic [GEN_BITS-1:0] g;
        s = $urandom_range(NUM_SLOTS - 1, 1);
        g = GEN_BITS'($urandom);
        if (tbl_live[PLAN][s])
        begin
            // A live slot only misses with a different generation.
            if (g == '0)
                g = GEN_BITS'(1);
            return tbl_handle[PLAN][s] ^ {g, SLOT_BITS'(0)};
        end
        return {g, SLOT_BITS'(s)};
    endfunction

    function automatic logic [OWNER_W-1:0] pick_tag();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_random(input int n, input int alloc_pct, input int free_pct,
                                       input int look_pct);
        int                 roll;
        logic [FIELD_W-1:0] h;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            h = ($urandom_range(4) == 0) ? pick_stale() : pick_live();
            if (roll < alloc_pct)
            begin
                if ($urandom_range(9) == 0)
                    add_item(REQ_ALLOC, FIELD_W'($urandom_range(65535, 1)), pick_tag());
                else
                    add_item(REQ_ALLOC, '0, pick_tag());
            end
            else if (roll < alloc_pct + free_pct)
                add_item(REQ_FREE, h, pick_tag());
            else if (roll < alloc_pct + free_pct + look_pct)
                add_item(REQ_LOOKUP, h, pick_tag());
            else
                add_item(2'($urandom), 16'($urandom), $urandom);
        end
    endfunction

    function automatic int idle_pct(input bit receiver);
        if (n_accepted * 3 < n_items)
            return receiver ? 51 : 12;
        else if (n_accepted * 3 < n_items * 2)
            return receiver ? 12 : 51;
        return 0;
    endfunction

    // Request driver: predicts each accepted transfer, then offers the next item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected = {expected, serve(CHECK, req)};
                n_accepted <= n_accepted + 1;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending.size() > 0 && $urandom_range(99) >= idle_pct(1'b0))
                begin
                    req <= pending.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected.size() == 0)
                begin
                    $error("response transfer with no request outstanding: %h", rsp);
                    n_errors++;
                end
                else
                begin
                    want_rsp = expected.pop_front();
                    if (rsp.result_handle !== want_rsp.result_handle)
                    begin
                        $error("result_handle: expected %h, got %h",
                               want_rsp.result_handle, rsp.result_handle);
                        n_errors++;
                    end
                    if (rsp.result_owner !== want_rsp.result_owner)
                    begin
                        $error("result_owner: expected %h, got %h",
                               want_rsp.result_owner, rsp.result_owner);
                        n_errors++;
                    end
                    if (rsp.status !== want_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
                        n_errors++;
                    end
                end
            end
            rsp_stall <= ($urandom_range(99) < idle_pct(1'b1));
        end
    end

    initial
    begin
        int                 target;
        logic [FIELD_W-1:0] h;
        bit                 timed_out;

        clear_model(PLAN);
        clear_model(CHECK);

        add_item(REQ_LOOKUP, '0, '0);
        add_item(REQ_FREE, '0, '1);
        add_item(REQ_UNUSED, 16'hFFFF, '1);
        add_item(REQ_ALLOC, '0, '1);
        add_item(REQ_ALLOC, '0, '0);
        add_item(REQ_ALLOC, 16'hFFFF, 32'h5A5A_A5A5);
        add_item(REQ_ALLOC, 16'h0001, '0);
        add_item(REQ_LOOKUP, 16'h0001, '0);
        add_item(REQ_LOOKUP, 16'h0002, '1);
        add_item(REQ_LOOKUP, 16'h0101, '0);
        add_item(REQ_FREE, 16'h0101, '0);
        add_item(REQ_FREE, 16'h0001, '0);
        add_item(REQ_LOOKUP, 16'h0001, '0);
        add_item(REQ_FREE, 16'h0001, '0);
        add_item(REQ_ALLOC, '0, 32'h8000_0001);
        add_item(REQ_LOOKUP, 16'h0101, '0);
        add_item(REQ_FREE, 16'h0002, '0);
        add_item(REQ_FREE, 16'h0101, '0);
        // The stack is last in, first out: slot 1, freed as 0x0101, comes back before slot 2.
        add_item(REQ_ALLOC, '0, 32'h0000_FFFF);
        add_item(REQ_ALLOC, '0, 32'hFFFF_0000);
        add_item(REQ_LOOKUP, 16'hFF00, '1);
        add_item(REQ_LOOKUP, 16'h00FF, '1);
        add_item(REQ_FREE, 16'hFFFF, '1);
        add_item(REQ_LOOKUP, 16'h0201, '0);
        add_item(REQ_LOOKUP, 16'h0102, '0);

        add_random(20, 40, 25, 25);

        // Fill the table until every slot but slot 0 is live, then ask for more.
        while (fresh_slot[PLAN] < NUM_SLOTS || recycle_count[PLAN] > 0)
        begin
            if ($urandom_range(99) < 97)
                add_item(REQ_ALLOC, '0, pick_tag());
            else
                add_item(REQ_LOOKUP, pick_live(), pick_tag());
        end
        repeat (4) add_item(REQ_ALLOC, '0, pick_tag());

        // Free and reallocate one slot until its generation wraps around.
        h = pick_live();
        target = int'(h[SLOT_BITS-1:0]);
        for (int i = 0; i < CHURN_PAIRS; i++)
        begin
            h = tbl_handle[PLAN][target];
            add_item(REQ_FREE, h, pick_tag());
            add_item(REQ_ALLOC, '0, pick_tag());
            if (i % 64 == 63)
            begin
                add_item(REQ_LOOKUP, h, pick_tag());
                add_item(REQ_ALLOC, '0, pick_tag());
                add_item(REQ_LOOKUP, pick_live(), pick_tag());
            end
        end

        add_random(20, 20, 50, 20);
        n_items = pending.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (!(pending.size() == 0 && !req_valid && expected.size() == 0)
               && cycle_count < LIMIT)
            @(posedge clk);
        timed_out = (cycle_count >= LIMIT);
        if (!timed_out)
            repeat (DRAIN_CYCLES) @(posedge clk);

        if (!timed_out && n_errors == 0 && expected.size() == 0)
            $display("generational_handle_allocator_unit: match");
        else
            $display("generational_handle_allocator_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

### generational_handle_allocator_unit.f
sv/gha_pkg.sv
sv/gha_ram.sv
sv/generational_handle_allocator_unit.sv
test/testbench.sv
